@@ hw/rtl/bvs_pkg.sv @@
// ----------------------------------------------------------------------------
// Block voltage statistics: shared package
// Field widths, register indexes, saturation limits and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package bvs_pkg;

  localparam int unsigned UV_W   = 23;
  localparam int unsigned SUM_W  = 56;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned ACC_W  = 64;
  localparam int unsigned RUN_W  = 8;
  localparam int unsigned CFG_W  = 13;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned DIVQ_W = 64;
  localparam int unsigned DIVD_W = 32;

  localparam logic [UV_W-1:0]  UV_MAX      = '1;
  localparam logic [IDX_W-1:0] CFG_REF_MV  = 8'd0;
  localparam logic [IDX_W-1:0] CFG_RUN_LIM = 8'd1;

  localparam logic [9:0]       MV_TO_UV         = 10'd1000;
  localparam logic [UV_W-1:0]  REF_SCALE_RESET  = 23'd3300000;
  localparam logic [RUN_W-1:0] RUN_LIMIT_RESET  = 8'd5;

  typedef struct packed {
    logic [RUN_W-1:0] run_number;
    logic [UV_W-1:0]  max_uv;
    logic [UV_W-1:0]  min_uv;
    logic [UV_W-1:0]  mean_uv;
    logic [UV_W-1:0]  stddev_uv;
    logic             final_run;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/bvs_front.sv @@
// ----------------------------------------------------------------------------
// Block voltage statistics: front end
// Scales each ADC code to microvolts and queues it for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bvs_front #(
  parameter int unsigned CODE_BITS = 12
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [CODE_BITS-1:0]     sample_code_i,
  input  wire logic [bvs_pkg::UV_W-1:0] ref_scale_i,
  output logic                          q_valid_o,
  input  wire logic                     q_stall_i,
  output logic [bvs_pkg::UV_W-1:0]      q_uv_o
);
  import bvs_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_B = $clog2(DEPTH + 1);

  logic [CODE_BITS+UV_W-1:0] prod;
  logic [UV_W-1:0]           uv;
  logic [UV_W-1:0]           slot_q [DEPTH];
  logic [PTR_W-1:0]          wr_q, wr_d, rd_q, rd_d;
  logic [CNT_B-1:0]          cnt_q, cnt_d;
  logic                      push, pop;

  // The scale already holds ref * 1000, so the shift is the divide by 2^CODE_BITS.
  assign prod = (CODE_BITS+UV_W)'(sample_code_i) * (CODE_BITS+UV_W)'(ref_scale_i);
  assign uv   = prod[CODE_BITS +: UV_W];

  assign in_stall_o = (cnt_q == CNT_B'(DEPTH));
  assign q_valid_o  = (cnt_q != '0);
  assign q_uv_o     = slot_q[rd_q];
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_valid_o && !q_stall_i;

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + CNT_B'(push) - CNT_B'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= uv;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bvs_div.sv @@
// ----------------------------------------------------------------------------
// Block voltage statistics: shared divider
// Restoring divider, one quotient bit per cycle, 64-bit by 32-bit.
// ----------------------------------------------------------------------------
`default_nettype none

module bvs_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [bvs_pkg::DIVQ_W-1:0] dividend_i,
  input  wire logic [bvs_pkg::DIVD_W-1:0] divisor_i,
  output logic                            done_o,
  output logic [bvs_pkg::DIVQ_W-1:0]      quotient_o
);
  import bvs_pkg::*;

  localparam int unsigned STEP_W = $clog2(DIVQ_W);

  logic [DIVQ_W-1:0] quo_q;
  logic [DIVD_W-1:0] rem_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q, done_q;
  logic [DIVD_W:0]   rem_sh, rem_sub;
  logic              ge;

  assign rem_sh  = {rem_q, quo_q[DIVQ_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor_i};
  assign ge      = (rem_sh >= {1'b0, divisor_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '1;
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVQ_W-2:0], ge};
      rem_q <= ge ? rem_sub[DIVD_W-1:0] : rem_sh[DIVD_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

@@ hw/rtl/bvs_back.sv @@
// ----------------------------------------------------------------------------
// Block voltage statistics: back end
// Keeps the running statistics and the block store, and closes each block
// with a mean division, a deviation sweep, a variance division and a root.
// ----------------------------------------------------------------------------
`default_nettype none

module bvs_back #(
  parameter int unsigned BLOCK_SIZE = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      q_valid_i,
  output logic                           q_stall_o,
  input  wire logic [bvs_pkg::UV_W-1:0]  q_uv_i,
  input  wire logic [bvs_pkg::RUN_W-1:0] run_limit_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output bvs_pkg::result_t               result_o
);
  import bvs_pkg::*;

  localparam int unsigned AW = $clog2(BLOCK_SIZE);

  localparam logic [3:0] S_RUN    = 4'd0;
  localparam logic [3:0] S_MSTART = 4'd1;
  localparam logic [3:0] S_MEAN   = 4'd2;
  localparam logic [3:0] S_SWEEP  = 4'd3;
  localparam logic [3:0] S_VSTART = 4'd4;
  localparam logic [3:0] S_VAR    = 4'd5;
  localparam logic [3:0] S_SQRT   = 4'd6;
  localparam logic [3:0] S_OUT    = 4'd7;

  logic [3:0]       state_q;
  logic [AW-1:0]    fill_q, rd_addr_q;
  logic             issued_q, v1_q, v2_q, rd_en;
  logic [UV_W-1:0]  mem_q [BLOCK_SIZE];
  logic [UV_W-1:0]  rdata_q, max_q, min_q, mean_q, dev;
  logic [SUM_W-1:0] sum_q;
  logic [SUM_W:0]   sum_add;
  logic [CNT_W-1:0] cnt_q;
  logic [2*UV_W-1:0] sq_q;
  logic [ACC_W-1:0] acc_q;
  logic [ACC_W:0]   acc_add;
  logic [ACC_W-1:0] rem_q, root_q, bit_q, trial;
  logic [RUN_W-1:0] run_q, run_next;
  logic             accept, last, div_start, div_done, load_out;
  logic [DIVQ_W-1:0] div_dividend, div_quo;
  result_t          res_q;
  logic             out_valid_q;

  assign q_stall_o = (state_q != S_RUN);
  assign accept    = q_valid_i && (state_q == S_RUN);
  assign last      = (fill_q == AW'(BLOCK_SIZE - 1));
  assign sum_add   = {1'b0, sum_q} + (SUM_W+1)'(q_uv_i);
  assign rd_en     = (state_q == S_SWEEP) && !issued_q;
  assign dev       = (rdata_q >= mean_q) ? rdata_q - mean_q : mean_q - rdata_q;
  assign acc_add   = {1'b0, acc_q} + (ACC_W+1)'(sq_q);
  assign trial     = root_q + bit_q;
  assign run_next  = run_q + 1'b1;
  assign load_out  = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  assign div_start    = (state_q == S_MSTART) || (state_q == S_VSTART);
  assign div_dividend = (state_q == S_MSTART) ? DIVQ_W'(sum_q) : acc_q;

  bvs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[fill_q] <= q_uv_i;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      fill_q      <= '0;
      max_q       <= '0;
      min_q       <= UV_MAX;
      sum_q       <= '0;
      cnt_q       <= '0;
      acc_q       <= '0;
      run_q       <= '0;
      rd_addr_q   <= '0;
      issued_q    <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= rd_en;
      v2_q <= v1_q;
      if (v2_q) begin
        acc_q <= acc_add[ACC_W] ? '1 : acc_add[ACC_W-1:0];
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_RUN: begin
          if (accept) begin
            if (q_uv_i > max_q) max_q <= q_uv_i;
            if (q_uv_i < min_q) min_q <= q_uv_i;
            sum_q <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            if (cnt_q != '1) cnt_q <= cnt_q + 1'b1;
            if (last) begin
              fill_q  <= '0;
              state_q <= S_MSTART;
            end else begin
              fill_q <= fill_q + 1'b1;
            end
          end
        end
        S_MSTART: state_q <= S_MEAN;
        S_MEAN: begin
          if (div_done) begin
            rd_addr_q <= '0;
            issued_q  <= 1'b0;
            state_q   <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (rd_en) begin
            rd_addr_q <= rd_addr_q + 1'b1;
            if (rd_addr_q == AW'(BLOCK_SIZE - 1)) issued_q <= 1'b1;
          end
          // Leave once the last square has gone into the accumulator.
          if (issued_q && !v1_q && !v2_q) state_q <= S_VSTART;
        end
        S_VSTART: state_q <= S_VAR;
        S_VAR:    if (div_done) state_q <= S_SQRT;
        S_SQRT:   if (bit_q == '0) state_q <= S_OUT;
        S_OUT: begin
          if (load_out) begin
            run_q   <= run_next;
            state_q <= S_RUN;
          end
        end
        default: state_q <= S_RUN;
      endcase
    end
  end

  // Payload side of the close sequence.
  always_ff @(posedge clk_i) begin
    if (state_q == S_MEAN && div_done) begin
      mean_q <= (div_quo[DIVQ_W-1:UV_W] != '0) ? UV_MAX : div_quo[UV_W-1:0];
    end
    if (v1_q) begin
      sq_q <= (2*UV_W)'(dev) * (2*UV_W)'(dev);
    end
    if (state_q == S_VAR && div_done) begin
      rem_q  <= div_quo;
      root_q <= '0;
      bit_q  <= ACC_W'(1) << (ACC_W - 2);
    end else if (state_q == S_SQRT && bit_q != '0) begin
      if (rem_q >= trial) begin
        rem_q  <= rem_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (load_out) begin
      res_q.run_number <= run_next;
      res_q.max_uv     <= max_q;
      res_q.min_uv     <= min_q;
      res_q.mean_uv    <= mean_q;
      res_q.stddev_uv  <= (root_q[ACC_W-1:UV_W] != '0) ? UV_MAX : root_q[UV_W-1:0];
      res_q.final_run  <= (run_next >= run_limit_i);
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

`default_nettype wire

@@ hw/rtl/block_voltage_statistics_core.sv @@
// ----------------------------------------------------------------------------
// Block voltage statistics core
// Running min, max, mean and standard deviation of ADC sample voltages,
// reported once per block of BLOCK_SIZE samples.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Payload
//  in       input      in_valid_i / in_stall_o   sample_code_i
//  out      output     out_valid_o / out_stall_i run_number_o .. final_run_o
//  cfg      input      cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// A sample is scaled by a combinational multiplier and written into a
// four-entry queue; the back end takes one sample per cycle while it is not
// closing a block. Before the result can load, closing a block runs two
// divider passes, each begun from a start state and ended by a done pulse,
// a sweep of the BLOCK_SIZE stored samples through the read, square and
// accumulate registers, and a bit-by-bit square root.
// Reset clears all statistics; stalls on the output hold the result and, once
// the close is done, hold the back end until the result is transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module block_voltage_statistics_core #(
  parameter int unsigned BLOCK_SIZE = 64,
  parameter int unsigned CODE_BITS  = 12
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [CODE_BITS-1:0]      sample_code_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [bvs_pkg::RUN_W-1:0]      run_number_o,
  output logic [bvs_pkg::UV_W-1:0]       max_uv_o,
  output logic [bvs_pkg::UV_W-1:0]       min_uv_o,
  output logic [bvs_pkg::UV_W-1:0]       mean_uv_o,
  output logic [bvs_pkg::UV_W-1:0]       stddev_uv_o,
  output logic                           final_run_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [bvs_pkg::IDX_W-1:0] cfg_index_i,
  input  wire logic [bvs_pkg::CFG_W-1:0] cfg_wdata_i
);
  import bvs_pkg::*;

  logic [UV_W-1:0]  ref_scale_q;
  logic [RUN_W-1:0] run_limit_q;
  logic             q_valid, q_stall;
  logic [UV_W-1:0]  q_uv;
  result_t          res;

  // The reference is kept premultiplied by 1000 so the front needs one multiplier.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_scale_q <= REF_SCALE_RESET;
      run_limit_q <= RUN_LIMIT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_REF_MV) begin
        ref_scale_q <= UV_W'(cfg_wdata_i) * UV_W'(MV_TO_UV);
      end else if (cfg_index_i == CFG_RUN_LIM) begin
        run_limit_q <= cfg_wdata_i[RUN_W-1:0];
      end
    end
  end

  bvs_front #(
    .CODE_BITS (CODE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_code_i (sample_code_i),
    .ref_scale_i   (ref_scale_q),
    .q_valid_o     (q_valid),
    .q_stall_i     (q_stall),
    .q_uv_o        (q_uv)
  );

  bvs_back #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_stall_o   (q_stall),
    .q_uv_i      (q_uv),
    .run_limit_i (run_limit_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (res)
  );

  assign run_number_o = res.run_number;
  assign max_uv_o     = res.max_uv;
  assign min_uv_o     = res.min_uv;
  assign mean_uv_o    = res.mean_uv;
  assign stddev_uv_o  = res.stddev_uv;
  assign final_run_o  = res.final_run;

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> min_uv_o <= max_uv_o)
    else $error("reported minimum exceeds maximum");

  a_final_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> final_run_o == (run_number_o >= run_limit_q))
    else $error("final-run flag disagrees with run number");

  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mean_uv_o >= min_uv_o) && (mean_uv_o <= max_uv_o))
    else $error("mean outside the min to max range");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// Block voltage statistics core: self-checking bench
// Streams ADC codes through the core under several reference and run-limit
// settings, predicts every block report in a scoreboard and compares the
// reports field by field, with random idling and a long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import bvs_pkg::*;

  localparam int unsigned BLOCK     = 64;
  localparam int unsigned CODE_W    = 12;
  localparam logic [IDX_W-1:0] CFG_UNUSED = 8'd2;

  // Scoreboard: keeps its own copy of the statistics and the expected reports.
  class voltage_stats_scoreboard;
    logic [CFG_W-1:0] ref_mv;
    logic [RUN_W-1:0] run_lim;
    logic [UV_W-1:0]  block_uv[BLOCK];
    int unsigned      fill;
    logic [UV_W-1:0]  max_uv, min_uv;
    logic [SUM_W-1:0] uv_sum;
    logic [CNT_W-1:0] n_samples;
    logic [ACC_W-1:0] dev_sq_acc;
    logic [RUN_W-1:0] runs;
    result_t          expected_reports[$];
    int unsigned      errors, reports_seen, samples_seen, reg_writes;

    function new();
      ref_mv     = 13'd3300;
      run_lim    = RUN_LIMIT_RESET;
      fill       = 0;
      max_uv     = '0;
      min_uv     = UV_MAX;
      uv_sum     = '0;
      n_samples  = '0;
      dev_sq_acc = '0;
      runs       = '0;
      errors     = 0;
      reports_seen = 0;
      samples_seen = 0;
      reg_writes   = 0;
    endfunction

    function logic [UV_W-1:0] clip_uv(logic [63:0] v);
      return (v > 64'(UV_MAX)) ? UV_MAX : v[UV_W-1:0];
    endfunction

    function logic [63:0] root_of(logic [63:0] v);
      logic [63:0] rem, root, bitv;
      rem  = v;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (rem >= root + bitv) begin
          rem  = rem - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      reg_writes++;
      if (idx == CFG_REF_MV) ref_mv = val;
      else if (idx == CFG_RUN_LIM) run_lim = val[RUN_W-1:0];
    endfunction

    function void note_sample(logic [CODE_W-1:0] code);
      logic [63:0]      scaled, sq, dev;
      logic [64:0]      acc_next;
      logic [56:0]      sum_next;
      logic [UV_W-1:0]  uv, mean;
      result_t          rep;
      samples_seen++;
      scaled = (64'(code) * 64'(ref_mv) * 64'd1000) >> CODE_W;
      uv = clip_uv(scaled);
      block_uv[fill] = uv;
      if (uv > max_uv) max_uv = uv;
      if (uv < min_uv) min_uv = uv;
      sum_next = 57'(uv_sum) + 57'(uv);
      uv_sum = sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
      if (n_samples != '1) n_samples++;
      fill++;
      if (fill < BLOCK) return;
      fill = 0;
      mean = clip_uv(64'(uv_sum) / 64'(n_samples));
      for (int k = 0; k < BLOCK; k++) begin
        dev = (block_uv[k] >= mean) ? 64'(block_uv[k] - mean) : 64'(mean - block_uv[k]);
        sq = dev * dev;
        acc_next = 65'(dev_sq_acc) + 65'(sq);
        dev_sq_acc = acc_next[64] ? '1 : acc_next[63:0];
      end
      runs = runs + 1'b1;
      rep.run_number = runs;
      rep.max_uv     = max_uv;
      rep.min_uv     = min_uv;
      rep.mean_uv    = mean;
      rep.stddev_uv  = clip_uv(root_of(dev_sq_acc / 64'(n_samples)));
      rep.final_run  = (runs >= run_lim);
      expected_reports.push_back(rep);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= 40)
        $display("MISMATCH report %0d: %s got %0d, expected %0d", reports_seen, what, got, want);
    endtask

    task check_result(result_t got);
      result_t want;
      reports_seen++;
      if (expected_reports.size() == 0) begin
        report("unexpected report, run_number", got.run_number, 0);
        return;
      end
      want = expected_reports.pop_front();
      if (got.run_number !== want.run_number) report("run_number", got.run_number, want.run_number);
      if (got.max_uv !== want.max_uv) report("max_uv", got.max_uv, want.max_uv);
      if (got.min_uv !== want.min_uv) report("min_uv", got.min_uv, want.min_uv);
      if (got.mean_uv !== want.mean_uv) report("mean_uv", got.mean_uv, want.mean_uv);
      if (got.stddev_uv !== want.stddev_uv) report("stddev_uv", got.stddev_uv, want.stddev_uv);
      if (got.final_run !== want.final_run) report("final_run", got.final_run, want.final_run);
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [CODE_W-1:0]   sample_code_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [RUN_W-1:0]    run_number_o;
  logic [UV_W-1:0]     max_uv_o, min_uv_o, mean_uv_o, stddev_uv_o;
  logic                final_run_o;
  logic                cfg_we_i = 1'b0;
  logic [IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_W-1:0]    cfg_wdata_i = '0;

  voltage_stats_scoreboard sb = new();
  bit                  calm = 1'b0;
  bit                  hold_req = 1'b0;
  logic [CODE_W-1:0]   steady_code;

  block_voltage_statistics_core #(.BLOCK_SIZE(BLOCK), .CODE_BITS(CODE_W)) uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sample_code_i,
    .out_valid_o, .out_stall_i, .run_number_o, .max_uv_o, .min_uv_o,
    .mean_uv_o, .stddev_uv_o, .final_run_o, .cfg_we_i, .cfg_index_i, .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Every transfer and register write is observed here, on the values held
  // just before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_index_i, cfg_wdata_i);
      if (in_valid_i && !in_stall_o) sb.note_sample(sample_code_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result('{run_number_o, max_uv_o, min_uv_o, mean_uv_o, stddev_uv_o,
                          final_run_o});
    end
  end

  // Receiver: random stalls, or a long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (900) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 10);
      end
    end
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

  task send_sample(logic [CODE_W-1:0] code);
    if (!calm && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_code_i <= code;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
  endtask

  // Lowers valid, waits until all reports are in and then idles on so that
  // the input queue drains and the core is quiet before registers change.
  task drain;
    in_valid_i <= 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task reconfigure(logic [CFG_W-1:0] mv, logic [RUN_W-1:0] lim);
    drain();
    write_reg(CFG_REF_MV, mv);
    write_reg(CFG_RUN_LIM, 13'(lim));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function logic [CODE_W-1:0] pick_code(int unsigned style);
    case (style)
      0: return CODE_W'($urandom);
      1: return steady_code;
      2: return $urandom_range(1) ? '1 : '0;
      default: return CODE_W'($urandom_range(2100, 2000));
    endcase
  endfunction

  task send_blocks(int unsigned n_items);
    int unsigned style;
    style = 0;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % BLOCK == 0) begin
        style = $urandom_range(3);
        steady_code = CODE_W'($urandom);
      end
      send_sample(pick_code(style));
    end
  endtask

  logic [CFG_W-1:0] mv_set[6]  = '{13'd5000, 13'd1, 13'd0, 13'd8191, 13'd4096, 13'd2500};
  logic [RUN_W-1:0] lim_set[6] = '{8'd1, 8'd0, 8'd255, 8'd3, 8'd200, 8'd12};

  initial begin
    logic [CODE_W-1:0] firsts[20];
    firsts = '{12'h000, 12'hFFF, 12'h001, 12'h800, 12'hAAA, 12'h555, 12'hFFE, 12'h7FF,
               12'h000, 12'hFFF, 12'h0F0, 12'hF0F, 12'h123, 12'hEDC, 12'h400, 12'hC00,
               12'h002, 12'hFFD, 12'h3FF, 12'hBFF};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings first: field extremes and alternating bit patterns.
    foreach (firsts[i]) send_sample(firsts[i]);
    send_blocks(300);

    // A write to an unused register index must leave both registers alone.
    drain();
    write_reg(CFG_UNUSED, 13'h1FFF);
    write_reg(8'hFF, 13'd7);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    send_blocks(130);

    for (int p = 0; p < 6; p++) begin
      reconfigure(mv_set[p], lim_set[p]);
      calm = (p == 3);
      // The receiver holds off while the sender keeps offering, so the input
      // queue fills and the core has to stall its input.
      if (p == 1) hold_req = 1'b1;
      send_blocks(200 + $urandom_range(63));
    end
    calm = 1'b0;

    reconfigure(13'($urandom_range(5000, 1)), 8'd255);
    send_blocks(150);

    drain();
    $display("Run covered %0d samples, %0d block reports and %0d register writes,",
             sb.samples_seen, sb.reports_seen, sb.reg_writes);
    $display("including zero and full-scale references, unused register indexes and a long hold-off.");
    if (sb.errors == 0 && sb.expected_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
